[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

[hdl/dnp3_pkg.sv]
// Shared constants, result codes and CRC helpers for the link frame receiver.
package dnp3_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h05;
  localparam logic [7:0] SYNC_SECOND = 8'h64;
  localparam logic [4:0] BLOCK_DATA  = 5'd16;
  localparam logic [4:0] HDR_CRC_LO  = 5'd8;
  localparam logic [4:0] HDR_CRC_HI  = 5'd9;
  localparam logic [7:0] MIN_LENGTH  = 8'd5;
  localparam logic [15:0] CRC_POLY   = 16'hA6BC;

  // Result kinds carried on m_tuser
  localparam logic [2:0] KIND_HDR_OK  = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_REJECT  = 3'd3;
  localparam logic [2:0] KIND_CRC_BAD = 3'd4;

  // Reject reasons
  localparam logic [1:0] RSN_CRC  = 2'd0;
  localparam logic [1:0] RSN_LEN  = 2'd1;
  localparam logic [1:0] RSN_FC   = 2'd2;
  localparam logic [1:0] RSN_ADDR = 2'd3;

  // Register word index
  localparam logic REG_STATION = 1'b0;

  // One byte of reflected CRC-16, unrolled.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic crc_match(input logic [15:0] crc, input logic [7:0] lo,
                                     input logic [7:0] hi);
    return ~crc == {hi, lo};
  endfunction

  function automatic logic fc_valid(input logic [7:0] ctl);
    logic [3:0] fc;
    fc = ctl[3:0];
    if (ctl[6]) begin
      return fc == 4'd0 || fc == 4'd2 || fc == 4'd3 || fc == 4'd4 || fc == 4'd9;
    end
    return ctl == 8'd0 || ctl == 8'd1 || ctl == 8'd11 || ctl == 8'd15;
  endfunction

endpackage

[hdl/dnp3_link_frame_receiver_core.sv]
// Link frame receiver: sync hunt, header check and block-wise user data pass-through.
// A result is registered and appears on the master side in the cycle after the byte that causes it.
// Throughput: one byte per cycle while s_tready is high; the byte and the result register update in one pass.
// s_tready drops only while a result is held and m_tready is low.
// Synchronous reset returns to the sync hunt, clears counters, CRC and station address.
// Header byte storage is not reset; it is always written before it is read.
module dnp3_link_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] data_byte, [15:8] frame_length, [23:16] control_byte,
  // [39:24] dest_address, [55:40] src_address, [57:56] reject_reason, rest zero
  output logic [63:0] m_tdata,
  output logic [2:0]  m_tuser,   // [2:0] kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dnp3_pkg::*;

  localparam logic [1:0] PH_SYNC1  = 2'd0;
  localparam logic [1:0] PH_SYNC2  = 2'd1;
  localparam logic [1:0] PH_HEADER = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  logic [15:0] station_address;
  logic [1:0]  phase, phase_next;
  logic [4:0]  byte_index, byte_index_next;
  logic [7:0]  hdr [2:7];
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_low, crc_low_next;
  logic [7:0]  data_remaining, data_remaining_next;
  logic        hdr_we;

  logic        out_kind_valid;
  logic [2:0]  res_kind;
  logic [7:0]  res_data;
  logic [1:0]  res_reason;

  logic [2:0]  out_kind;
  logic [7:0]  out_data, out_len, out_ctl;
  logic [15:0] out_dst, out_src;
  logic [1:0]  out_reason;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_step;
  logic [7:0]  rem_dec;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_STATION) ? {16'h0000, station_address} : 32'h0;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign crc_step = crc_add(crc, b);
  assign rem_dec  = data_remaining - 8'd1;

  assign m_tuser = out_kind;
  assign m_tdata = {6'b0, out_reason, out_src, out_dst, out_ctl, out_len, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STATION) begin
      station_address <= pwdata[15:0];
    end
  end

  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    crc_next            = crc;
    crc_low_next        = crc_low;
    data_remaining_next = data_remaining;
    hdr_we              = 1'b0;
    out_kind_valid      = 1'b0;
    res_kind            = KIND_HDR_OK;
    res_data            = 8'h00;
    res_reason          = RSN_CRC;
    case (phase)
      PH_SYNC1: begin
        if (b == SYNC_FIRST) begin
          crc_next   = crc_add(16'h0000, b);
          phase_next = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          crc_next        = crc_step;
          byte_index_next = 5'd2;
          phase_next      = PH_HEADER;
        end else if (b == SYNC_FIRST) begin
          crc_next = crc_add(16'h0000, b);
        end else begin
          phase_next          = PH_SYNC1;
          byte_index_next     = '0;
          crc_next            = '0;
          data_remaining_next = '0;
        end
      end
      PH_HEADER: begin
        if (byte_index < HDR_CRC_LO) begin
          hdr_we          = 1'b1;
          crc_next        = crc_step;
          byte_index_next = byte_index + 5'd1;
        end else if (byte_index == HDR_CRC_LO) begin
          crc_low_next    = b;
          byte_index_next = HDR_CRC_HI;
        end else begin
          out_kind_valid = 1'b1;
          // checks in priority order; first failure names the reason
          if (!crc_match(crc, crc_low, b)) begin
            res_kind = KIND_REJECT;
            res_reason = RSN_CRC;
          end else if (hdr[2] < MIN_LENGTH) begin
            res_kind = KIND_REJECT;
            res_reason = RSN_LEN;
          end else if (!fc_valid(hdr[3])) begin
            res_kind = KIND_REJECT;
            res_reason = RSN_FC;
          end else if ({hdr[5], hdr[4]} != station_address) begin
            res_kind = KIND_REJECT;
            res_reason = RSN_ADDR;
          end else if (hdr[2] == MIN_LENGTH) begin
            res_kind = KIND_DONE;
          end else begin
            res_kind = KIND_HDR_OK;
          end
          if (res_kind == KIND_HDR_OK) begin
            data_remaining_next = hdr[2] - MIN_LENGTH;
            byte_index_next     = '0;
            crc_next            = '0;
            phase_next          = PH_DATA;
          end else begin
            phase_next          = PH_SYNC1;
            byte_index_next     = '0;
            crc_next            = '0;
            data_remaining_next = '0;
          end
        end
      end
      PH_DATA: begin
        if (byte_index < BLOCK_DATA && data_remaining != 8'd0) begin
          crc_next            = crc_step;
          data_remaining_next = rem_dec;
          byte_index_next     = (rem_dec == 8'd0) ? BLOCK_DATA : byte_index + 5'd1;
          out_kind_valid      = 1'b1;
          res_kind            = KIND_DATA;
          res_data            = b;
        end else if (byte_index <= BLOCK_DATA) begin
          crc_low_next    = b;
          byte_index_next = BLOCK_DATA + 5'd1;
        end else if (!crc_match(crc, crc_low, b) || data_remaining == 8'd0) begin
          out_kind_valid      = 1'b1;
          res_kind            = crc_match(crc, crc_low, b) ? KIND_DONE : KIND_CRC_BAD;
          phase_next          = PH_SYNC1;
          byte_index_next     = '0;
          crc_next            = '0;
          data_remaining_next = '0;
        end else begin
          // good block CRC, more data follows
          byte_index_next = '0;
          crc_next        = '0;
        end
      end
      default: begin
        phase_next = PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      byte_index     <= '0;
      crc            <= '0;
      crc_low        <= '0;
      data_remaining <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        byte_index     <= byte_index_next;
        crc            <= crc_next;
        crc_low        <= crc_low_next;
        data_remaining <= data_remaining_next;
      end
      if (accept && out_kind_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_we) begin
      hdr[byte_index[2:0]] <= b;
    end
    if (accept && out_kind_valid) begin
      out_kind   <= res_kind;
      out_data   <= res_data;
      out_reason <= res_reason;
      out_len    <= hdr[2];
      out_ctl    <= hdr[3];
      out_dst    <= {hdr[5], hdr[4]};
      out_src    <= {hdr[7], hdr[6]};
    end
  end

endmodule

[hdl/dnp3_checker.sv]
// Port-level checker for the link frame receiver, bound to the receiver core.
`include "assert_macros.svh"

module dnp3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import dnp3_pkg::*;

  // a held result keeps its contents
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser}))

  // input side is open whenever the result register is free
  `ASSERT_CLK(a_in_open, clk, rst, !m_tvalid |-> s_tready)

  `ASSERT_NEVER(a_kind_range, clk, rst, m_tvalid && m_tuser > KIND_CRC_BAD)

  // data byte is zero except on data results
  `ASSERT_CLK(a_data_zero, clk, rst, m_tvalid && m_tuser != KIND_DATA |-> m_tdata[7:0] == 8'h00)

  // reason is zero except on rejects
  `ASSERT_CLK(a_reason_zero, clk, rst, m_tvalid && m_tuser != KIND_REJECT |-> m_tdata[57:56] == RSN_CRC)

endmodule

bind dnp3_link_frame_receiver_core dnp3_checker u_dnp3_checker (.*);

[verif/dnp3_link_frame_receiver_checker.sv]
// Link frame receiver checker: shared test constants, deframer predictor and result compare.
`timescale 1ns / 100ps

package dnp3_link_tb_pkg;
  import dnp3_pkg::*;

  localparam logic [15:0] DNP_CRC_POLY = 16'hA6BC;
  localparam logic [2:0]  STATION_PADDR = {REG_STATION, 2'b00};

  localparam logic [7:0] PRM_FLAG = 8'h40;

  // primary function codes that the receiver accepts, plus one it must refuse
  localparam logic [3:0] FC_PRI_RESET_LINK  = 4'd0;
  localparam logic [3:0] FC_PRI_OBSOLETE    = 4'd1;
  localparam logic [3:0] FC_PRI_TEST_LINK   = 4'd2;
  localparam logic [3:0] FC_PRI_CONFIRMED   = 4'd3;
  localparam logic [3:0] FC_PRI_UNCONFIRMED = 4'd4;
  localparam logic [3:0] FC_PRI_LINK_STATUS = 4'd9;

  // secondary control bytes (PRM clear)
  localparam logic [7:0] CTL_SEC_ACK           = 8'd0;
  localparam logic [7:0] CTL_SEC_NACK          = 8'd1;
  localparam logic [7:0] CTL_SEC_RESERVED      = 8'd2;
  localparam logic [7:0] CTL_SEC_LINK_STATUS   = 8'd11;
  localparam logic [7:0] CTL_SEC_NOT_SUPPORTED = 8'd15;

  // reflected CRC-16, one byte at a time
  function automatic logic [15:0] crc16_dnp_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ DNP_CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module dnp3_link_frame_receiver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatch_count,
  output int unsigned results_due
);
  import dnp3_pkg::*;
  import dnp3_link_tb_pkg::*;

  typedef enum logic [1:0] {HUNT_05, HUNT_64, IN_HEADER, IN_DATA} rx_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [7:0]  len;
    logic [7:0]  ctl;
    logic [15:0] dst;
    logic [15:0] src;
    logic [1:0]  why;
  } link_result_t;

  rx_phase_t    ph;
  logic [4:0]   idx;
  logic [7:0]   hdr [8];
  logic [15:0]  acc;
  logic [7:0]   crc_lo;
  logic [7:0]   left;
  logic [15:0]  station;
  link_result_t expected_results [$];

  function automatic bit control_ok(input logic [7:0] c);
    if ((c & PRM_FLAG) != 8'h00) begin
      return c[3:0] == FC_PRI_RESET_LINK || c[3:0] == FC_PRI_TEST_LINK ||
             c[3:0] == FC_PRI_CONFIRMED || c[3:0] == FC_PRI_UNCONFIRMED ||
             c[3:0] == FC_PRI_LINK_STATUS;
    end
    return c == CTL_SEC_ACK || c == CTL_SEC_NACK || c == CTL_SEC_LINK_STATUS ||
           c == CTL_SEC_NOT_SUPPORTED;
  endfunction

  task automatic restart_hunt();
    ph = HUNT_05;
    idx = '0;
    acc = '0;
    left = '0;
  endtask

  // Advance the deframer by one received byte and queue the result it produces.
  task automatic advance_deframer(input logic [7:0] b);
    bit           emit;
    link_result_t r;
    emit = 0;
    r.kind = KIND_HDR_OK;
    r.data = 8'h00;
    r.why = RSN_CRC;
    case (ph)
      HUNT_05: begin
        if (b == SYNC_FIRST) begin
          acc = crc16_dnp_step(16'h0000, b);
          ph = HUNT_64;
        end
      end
      HUNT_64: begin
        if (b == SYNC_SECOND) begin
          hdr[0] = SYNC_FIRST;
          hdr[1] = SYNC_SECOND;
          acc = crc16_dnp_step(acc, b);
          idx = 5'd2;
          ph = IN_HEADER;
        end else if (b == SYNC_FIRST) begin
          acc = crc16_dnp_step(16'h0000, b);
        end else begin
          restart_hunt();
        end
      end
      IN_HEADER: begin
        if (idx < 5'd8) begin
          hdr[idx[2:0]] = b;
          acc = crc16_dnp_step(acc, b);
          idx++;
        end else if (idx == 5'd8) begin
          crc_lo = b;
          idx = 5'd9;
        end else begin
          emit = 1;
          r.kind = KIND_REJECT;
          if (~acc != {b, crc_lo}) r.why = RSN_CRC;
          else if (hdr[2] < MIN_LENGTH) r.why = RSN_LEN;
          else if (!control_ok(hdr[3])) r.why = RSN_FC;
          else if ({hdr[5], hdr[4]} != station) r.why = RSN_ADDR;
          else if (hdr[2] == MIN_LENGTH) r.kind = KIND_DONE;
          else r.kind = KIND_HDR_OK;
          if (r.kind == KIND_HDR_OK) begin
            left = hdr[2] - MIN_LENGTH;
            idx = '0;
            acc = '0;
            ph = IN_DATA;
          end else begin
            restart_hunt();
          end
        end
      end
      default: begin
        if (idx < BLOCK_DATA && left != 8'h00) begin
          acc = crc16_dnp_step(acc, b);
          idx++;
          left--;
          if (left == 8'h00) idx = BLOCK_DATA;
          emit = 1;
          r.kind = KIND_DATA;
          r.data = b;
        end else if (idx <= BLOCK_DATA) begin
          crc_lo = b;
          idx = BLOCK_DATA + 5'd1;
        end else if (~acc != {b, crc_lo}) begin
          emit = 1;
          r.kind = KIND_CRC_BAD;
          restart_hunt();
        end else if (left == 8'h00) begin
          emit = 1;
          r.kind = KIND_DONE;
          restart_hunt();
        end else begin
          // block good, next block follows
          idx = '0;
          acc = '0;
        end
      end
    endcase
    if (emit) begin
      r.len = hdr[2];
      r.ctl = hdr[3];
      r.dst = {hdr[5], hdr[4]};
      r.src = {hdr[7], hdr[6]};
      expected_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    link_result_t want;
    if (rst) begin
      restart_hunt();
      crc_lo = '0;
      station = '0;
      foreach (hdr[i]) hdr[i] = '0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      // retire the result first: a byte taken on this edge shows up later
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: kind 0x%0h with nothing expected", m_tuser);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(m_tuser));
          check_field("data_byte", 16'(want.data), 16'(m_tdata[7:0]));
          check_field("frame_length", 16'(want.len), 16'(m_tdata[15:8]));
          check_field("control_byte", 16'(want.ctl), 16'(m_tdata[23:16]));
          check_field("dest_address", want.dst, m_tdata[39:24]);
          check_field("src_address", want.src, m_tdata[55:40]);
          check_field("reject_reason", 16'(want.why), 16'(m_tdata[57:56]));
          check_field("tdata padding", 16'h0000, 16'(m_tdata[63:58]));
        end
      end
      if (psel && penable && pwrite && pready && paddr == STATION_PADDR) begin
        station = pwdata[15:0];
      end
      if (s_tvalid && s_tready) advance_deframer(s_tdata);
    end
    results_due <= expected_results.size();
  end

endmodule

[verif/dnp3_link_frame_receiver_core_test.sv]
// Top-level testbench for the link frame receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module dnp3_link_frame_receiver_core_test;
  import dnp3_pkg::*;
  import dnp3_link_tb_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BYTES = 300;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatch_count;
  int unsigned results_due;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          phase_bytes = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  logic [15:0] station = 16'h0000;
  logic [7:0]  tx_q [$];

  dnp3_link_frame_receiver_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dnp3_link_frame_receiver_checker frame_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off per request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_station(input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= STATION_PADDR;
    pwdata <= {16'($urandom()), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_queued();
    while (tx_q.size() != 0) begin
      push_byte(tx_q.pop_front());
      phase_bytes++;
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Append a well-formed frame: header with its CRC, then data in 16-byte blocks.
  task automatic build_frame(input logic [7:0] len, input logic [7:0] ctl,
                             input logic [15:0] dst, input logic [15:0] src);
    logic [7:0]  hb [8];
    logic [7:0]  d;
    logic [15:0] acc;
    int          n_data;
    int          in_blk;
    hb = '{SYNC_FIRST, SYNC_SECOND, len, ctl, dst[7:0], dst[15:8], src[7:0], src[15:8]};
    acc = 16'h0000;
    foreach (hb[i]) begin
      tx_q.push_back(hb[i]);
      acc = crc16_dnp_step(acc, hb[i]);
    end
    tx_q.push_back(~acc[7:0]);
    tx_q.push_back(~acc[15:8]);
    n_data = (len > MIN_LENGTH) ? int'(len - MIN_LENGTH) : 0;
    acc = 16'h0000;
    in_blk = 0;
    for (int i = 0; i < n_data; i++) begin
      d = 8'($urandom());
      tx_q.push_back(d);
      acc = crc16_dnp_step(acc, d);
      in_blk++;
      if (in_blk == 16 || i == n_data - 1) begin
        tx_q.push_back(~acc[7:0]);
        tx_q.push_back(~acc[15:8]);
        acc = 16'h0000;
        in_blk = 0;
      end
    end
  endtask

  // Mostly good frames with random content; some line noise, corruption and cut-offs.
  task automatic random_frame();
    logic [7:0]  len;
    logic [7:0]  ctl;
    logic [15:0] dst;
    int          pick;
    int          cut;
    int          n;
    n = ($urandom_range(99) < 25) ? $urandom_range(5, 1) : 0;
    repeat (n) tx_q.push_back(8'($urandom()));
    pick = $urandom_range(99);
    if (pick < 5) len = 8'($urandom_range(4));
    else if (pick < 7) len = 8'd255;
    else if (pick < 10) len = 8'($urandom_range(255, 41));
    else len = 8'($urandom_range(40, 5));
    pick = $urandom_range(99);
    if (pick < 40) begin
      ctl = 8'($urandom()) | PRM_FLAG;
      case ($urandom_range(4))
        0: ctl[3:0] = FC_PRI_RESET_LINK;
        1: ctl[3:0] = FC_PRI_TEST_LINK;
        2: ctl[3:0] = FC_PRI_CONFIRMED;
        3: ctl[3:0] = FC_PRI_UNCONFIRMED;
        default: ctl[3:0] = FC_PRI_LINK_STATUS;
      endcase
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0: ctl = CTL_SEC_ACK;
        1: ctl = CTL_SEC_NACK;
        2: ctl = CTL_SEC_LINK_STATUS;
        default: ctl = CTL_SEC_NOT_SUPPORTED;
      endcase
    end else begin
      ctl = 8'($urandom());
    end
    dst = ($urandom_range(99) < 85) ? station : 16'($urandom());
    build_frame(len, ctl, dst, 16'($urandom()));
    pick = $urandom_range(99);
    if (pick < 8) begin
      cut = $urandom_range(tx_q.size() - 1, n + 2);
      tx_q[cut] ^= 8'($urandom_range(255, 1));
    end else if (pick < 14) begin
      cut = $urandom_range(tx_q.size() - 1, n + 1);
      while (tx_q.size() > cut) void'(tx_q.pop_back());
    end
    send_queued();
  endtask

  initial begin : stimulus
    int base;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  station = 16'h0000; end
        1: begin idle_pct = 59; stall_pct = 0;  station = 16'($urandom()); end
        2: begin idle_pct = 0;  stall_pct = 59; station = 16'hFFFF; end
        3: begin idle_pct = 17; stall_pct = 17; station = 16'($urandom()); end
        default: begin idle_pct = 0; stall_pct = 0; station = 16'($urandom()); end
      endcase
      write_station(station);

      if (p == 0) begin
        // junk, a lone 0x05, then a doubled 0x05 ahead of a real sync pair
        tx_q = '{8'h00, 8'hFF, SYNC_FIRST, 8'hA5, SYNC_FIRST};
        build_frame(MIN_LENGTH, PRM_FLAG | {4'h0, FC_PRI_TEST_LINK}, station, 16'hFFFF);
        // one full block plus a one-byte tail block
        build_frame(8'd22, PRM_FLAG | {4'h0, FC_PRI_UNCONFIRMED}, station, 16'h0000);
        base = tx_q.size();
        build_frame(MIN_LENGTH, CTL_SEC_ACK, station, 16'h1234);
        tx_q[base + 9] ^= 8'h80;
        build_frame(8'd4, CTL_SEC_ACK, station, 16'h0001);
        build_frame(MIN_LENGTH, PRM_FLAG | {4'h0, FC_PRI_OBSOLETE}, station, 16'h0002);
        build_frame(MIN_LENGTH, CTL_SEC_RESERVED, station, 16'h0003);
        build_frame(MIN_LENGTH, CTL_SEC_NOT_SUPPORTED, ~station, 16'h0004);
        build_frame(8'd8, CTL_SEC_NACK, station, 16'h8000);
        tx_q[tx_q.size() - 1] ^= 8'h01;
        build_frame(8'd6, CTL_SEC_LINK_STATUS, station, 16'h7FFF);
        send_queued();
      end

      // last phase: long receiver hold-off while the sender keeps going
      if (p == 4) hold_requests++;

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        random_frame();
        if ($urandom_range(19) == 0) wait_for_results();
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/dnp3_pkg.sv
hdl/dnp3_link_frame_receiver_core.sv
hdl/dnp3_checker.sv
verif/dnp3_link_frame_receiver_checker.sv
verif/dnp3_link_frame_receiver_core_test.sv
